FILE: src/altitude_kalman_filter_3state_macros.svh
// assertion macros for the altitude kalman filter
`ifndef ALTITUDE_KALMAN_FILTER_3STATE_MACROS_SVH
`define ALTITUDE_KALMAN_FILTER_3STATE_MACROS_SVH
`ifndef SYNTHESIS
`define AKF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AKF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AKF_ASSERT(lbl, prop, msg)
`define AKF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: src/akf_pkg.sv
// types, constants and micro-op programs of the altitude kalman filter
`timescale 1ns / 1ps
package akf_pkg;

    typedef logic signed [47:0] q_t;
    typedef logic [4:0]         addr_t;

    localparam q_t QMAX   = 48'sh7FFF_FFFF_FFFF;
    localparam q_t QMIN   = 48'sh8000_0000_0000;
    localparam q_t ONE_Q  = 48'sd16777216;
    localparam q_t BIAS_P0 = 48'sd1677721600000;
    localparam int DIV_STEPS = 50;
    localparam int STATE_WORDS = 12;

    typedef struct packed {
        logic        kind;
        logic [31:0] accel_sample;
        logic [23:0] time_step;
        logic [31:0] measured_altitude;
    } akf_in_t;

    typedef struct packed {
        logic [31:0] altitude_estimate;
        logic [31:0] velocity_estimate;
        logic [31:0] bias_estimate;
    } akf_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] value;
    } akf_cfg_t;

    typedef enum logic [1:0] {
        REG_ALT_NOISE,
        REG_ACCEL_NOISE,
        REG_BIAS_NOISE
    } reg_index_t;

    // state memory map
    localparam addr_t AD_P0 = 5'd0;
    localparam addr_t AD_P1 = 5'd1;
    localparam addr_t AD_P2 = 5'd2;
    localparam addr_t AD_P3 = 5'd3;
    localparam addr_t AD_P4 = 5'd4;
    localparam addr_t AD_P5 = 5'd5;
    localparam addr_t AD_P6 = 5'd6;
    localparam addr_t AD_P7 = 5'd7;
    localparam addr_t AD_P8 = 5'd8;
    localparam addr_t AD_ALT = 5'd9;
    localparam addr_t AD_VEL = 5'd10;
    localparam addr_t AD_BIAS = 5'd11;
    // predict scratch
    localparam addr_t AD_HF = 5'd12;
    localparam addr_t AD_DD = 5'd13;
    localparam addr_t AD_D3 = 5'd14;
    localparam addr_t AD_D4 = 5'd15;
    localparam addr_t AD_ACC = 5'd16;
    localparam addr_t AD_T00 = 5'd17;
    localparam addr_t AD_T01 = 5'd18;
    localparam addr_t AD_T02 = 5'd19;
    localparam addr_t AD_T10 = 5'd20;
    localparam addr_t AD_T11 = 5'd21;
    localparam addr_t AD_T12 = 5'd22;
    // correct scratch
    localparam addr_t AD_INNOV = 5'd12;
    localparam addr_t AD_DEN = 5'd13;
    localparam addr_t AD_S = 5'd14;
    localparam addr_t AD_KZ = 5'd15;
    localparam addr_t AD_KV = 5'd16;
    localparam addr_t AD_KA = 5'd17;
    // operands taken from item and register values
    localparam addr_t EXT_BASE = 5'd24;
    localparam addr_t AD_ZERO = 5'd24;
    localparam addr_t AD_A = 5'd25;
    localparam addr_t AD_DT = 5'd26;
    localparam addr_t AD_QA = 5'd27;
    localparam addr_t AD_BN = 5'd28;
    localparam addr_t AD_RN = 5'd29;
    localparam addr_t AD_Z = 5'd30;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_PASS,
        OP_HALF,
        OP_DIV
    } op_mode_t;

    // dst = sat(x +/- w), w = y*z, y, y/2 or 1/y
    typedef struct packed {
        addr_t    dst;
        addr_t    x;
        addr_t    y;
        addr_t    z;
        op_mode_t mode;
        logic     sub;
        logic     last;
    } uop_t;

    function automatic uop_t mk(addr_t dst, addr_t x, addr_t y, addr_t z,
                                op_mode_t mode, logic sub, logic last);
        uop_t u;
        u.dst  = dst;
        u.x    = x;
        u.y    = y;
        u.z    = z;
        u.mode = mode;
        u.sub  = sub;
        u.last = last;
        return u;
    endfunction

    function automatic uop_t predict_op(logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = mk(AD_ACC, AD_A, AD_BIAS, AD_ZERO, OP_PASS, 1'b1, 1'b0);
            5'd1:  u = mk(AD_VEL, AD_VEL, AD_ACC, AD_DT, OP_MUL, 1'b0, 1'b0);
            5'd2:  u = mk(AD_ALT, AD_ALT, AD_VEL, AD_DT, OP_MUL, 1'b0, 1'b0);
            5'd3:  u = mk(AD_DD, AD_ZERO, AD_DT, AD_DT, OP_MUL, 1'b0, 1'b0);
            5'd4:  u = mk(AD_HF, AD_ZERO, AD_DD, AD_ZERO, OP_HALF, 1'b0, 1'b0);
            5'd5:  u = mk(AD_D3, AD_ZERO, AD_HF, AD_DT, OP_MUL, 1'b0, 1'b0);
            5'd6:  u = mk(AD_D4, AD_ZERO, AD_HF, AD_HF, OP_MUL, 1'b0, 1'b0);
            5'd7:  u = mk(AD_T00, AD_P0, AD_DT, AD_P3, OP_MUL, 1'b0, 1'b0);
            5'd8:  u = mk(AD_T00, AD_T00, AD_HF, AD_P6, OP_MUL, 1'b1, 1'b0);
            5'd9:  u = mk(AD_T01, AD_P1, AD_DT, AD_P4, OP_MUL, 1'b0, 1'b0);
            5'd10: u = mk(AD_T01, AD_T01, AD_HF, AD_P7, OP_MUL, 1'b1, 1'b0);
            5'd11: u = mk(AD_T02, AD_P2, AD_DT, AD_P5, OP_MUL, 1'b0, 1'b0);
            5'd12: u = mk(AD_T02, AD_T02, AD_HF, AD_P8, OP_MUL, 1'b1, 1'b0);
            5'd13: u = mk(AD_T10, AD_P3, AD_DT, AD_P6, OP_MUL, 1'b1, 1'b0);
            5'd14: u = mk(AD_T11, AD_P4, AD_DT, AD_P7, OP_MUL, 1'b1, 1'b0);
            5'd15: u = mk(AD_T12, AD_P5, AD_DT, AD_P8, OP_MUL, 1'b1, 1'b0);
            5'd16: u = mk(AD_P0, AD_T00, AD_DT, AD_T01, OP_MUL, 1'b0, 1'b0);
            5'd17: u = mk(AD_P0, AD_P0, AD_HF, AD_T02, OP_MUL, 1'b1, 1'b0);
            5'd18: u = mk(AD_P1, AD_T01, AD_DT, AD_T02, OP_MUL, 1'b1, 1'b0);
            5'd19: u = mk(AD_P2, AD_T02, AD_ZERO, AD_ZERO, OP_PASS, 1'b0, 1'b0);
            5'd20: u = mk(AD_P3, AD_T10, AD_DT, AD_T11, OP_MUL, 1'b0, 1'b0);
            5'd21: u = mk(AD_P3, AD_P3, AD_HF, AD_T12, OP_MUL, 1'b1, 1'b0);
            5'd22: u = mk(AD_P4, AD_T11, AD_DT, AD_T12, OP_MUL, 1'b1, 1'b0);
            5'd23: u = mk(AD_P5, AD_T12, AD_ZERO, AD_ZERO, OP_PASS, 1'b0, 1'b0);
            5'd24: u = mk(AD_P6, AD_P6, AD_DT, AD_P7, OP_MUL, 1'b0, 1'b0);
            5'd25: u = mk(AD_P6, AD_P6, AD_HF, AD_P8, OP_MUL, 1'b1, 1'b0);
            5'd26: u = mk(AD_P7, AD_P7, AD_DT, AD_P8, OP_MUL, 1'b1, 1'b0);
            5'd27: u = mk(AD_P0, AD_P0, AD_D4, AD_QA, OP_MUL, 1'b0, 1'b0);
            5'd28: u = mk(AD_P1, AD_P1, AD_D3, AD_QA, OP_MUL, 1'b0, 1'b0);
            5'd29: u = mk(AD_P3, AD_P3, AD_D3, AD_QA, OP_MUL, 1'b0, 1'b0);
            5'd30: u = mk(AD_P4, AD_P4, AD_DD, AD_QA, OP_MUL, 1'b0, 1'b0);
            5'd31: u = mk(AD_P8, AD_P8, AD_BN, AD_ZERO, OP_PASS, 1'b0, 1'b1);
            default: u = mk(AD_P8, AD_P8, AD_BN, AD_ZERO, OP_PASS, 1'b0, 1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t correct_op(logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = mk(AD_INNOV, AD_Z, AD_ALT, AD_ZERO, OP_PASS, 1'b1, 1'b0);
            5'd1:  u = mk(AD_DEN, AD_P0, AD_RN, AD_ZERO, OP_PASS, 1'b0, 1'b0);
            5'd2:  u = mk(AD_S, AD_ZERO, AD_DEN, AD_ZERO, OP_DIV, 1'b0, 1'b0);
            5'd3:  u = mk(AD_KZ, AD_ZERO, AD_P0, AD_S, OP_MUL, 1'b0, 1'b0);
            5'd4:  u = mk(AD_KV, AD_ZERO, AD_P3, AD_S, OP_MUL, 1'b0, 1'b0);
            5'd5:  u = mk(AD_KA, AD_ZERO, AD_P6, AD_S, OP_MUL, 1'b0, 1'b0);
            5'd6:  u = mk(AD_ALT, AD_ALT, AD_KZ, AD_INNOV, OP_MUL, 1'b0, 1'b0);
            5'd7:  u = mk(AD_VEL, AD_VEL, AD_KV, AD_INNOV, OP_MUL, 1'b0, 1'b0);
            5'd8:  u = mk(AD_BIAS, AD_BIAS, AD_KA, AD_INNOV, OP_MUL, 1'b0, 1'b0);
            5'd9:  u = mk(AD_P6, AD_P6, AD_KA, AD_P0, OP_MUL, 1'b1, 1'b0);
            5'd10: u = mk(AD_P7, AD_P7, AD_KA, AD_P1, OP_MUL, 1'b1, 1'b0);
            5'd11: u = mk(AD_P8, AD_P8, AD_KA, AD_P2, OP_MUL, 1'b1, 1'b0);
            5'd12: u = mk(AD_P3, AD_P3, AD_KV, AD_P0, OP_MUL, 1'b1, 1'b0);
            5'd13: u = mk(AD_P4, AD_P4, AD_KV, AD_P1, OP_MUL, 1'b1, 1'b0);
            5'd14: u = mk(AD_P5, AD_P5, AD_KV, AD_P2, OP_MUL, 1'b1, 1'b0);
            5'd15: u = mk(AD_P0, AD_P0, AD_KZ, AD_P0, OP_MUL, 1'b1, 1'b0);
            5'd16: u = mk(AD_P1, AD_P1, AD_KZ, AD_P1, OP_MUL, 1'b1, 1'b0);
            5'd17: u = mk(AD_P2, AD_P2, AD_KZ, AD_P2, OP_MUL, 1'b1, 1'b1);
            default: u = mk(AD_P2, AD_P2, AD_KZ, AD_P2, OP_MUL, 1'b1, 1'b1);
        endcase
        return u;
    endfunction

    function automatic q_t sat49(logic signed [48:0] v);
        q_t r;
        if (v > 49'sh0_7FFF_FFFF_FFFF) r = QMAX;
        else if (v < -49'sh0_8000_0000_0000) r = QMIN;
        else r = v[47:0];
        return r;
    endfunction

    // q24.24 to q16.16, rounded and saturated
    function automatic logic [31:0] to_port(q_t x);
        logic signed [48:0] y;
        logic signed [40:0] r;
        logic [31:0] o;
        y = 49'(x) + 49'sd128;
        r = 41'(y >>> 8);
        if (r > 41'sd2147483647) o = 32'h7FFF_FFFF;
        else if (r < -41'sd2147483648) o = 32'h8000_0000;
        else o = r[31:0];
        return o;
    endfunction

endpackage

FILE: src/akf_chan_if.sv
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
interface akf_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/akf_ram.sv
// generic two-read one-write ram with registered reads
`timescale 1ns / 1ps
module akf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

FILE: src/akf_mul.sv
// q24.24 multiplier, rounded and saturated, one 24x24 product per cycle
`timescale 1ns / 1ps
module akf_mul import akf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  q_t   a,
    input  q_t   b,
    output logic done,
    output q_t   product
);
    logic [2:0]  cnt_reg;
    logic [47:0] ua_reg, ub_reg;
    logic        neg_reg, hsat_reg, done_reg;
    logic [22:0] hh_reg;
    logic [49:0] acc_reg;
    q_t          product_reg;
    logic [23:0] opx, opy;
    logic [47:0] pp;
    logic [50:0] m;
    logic [48:0] pr;

    always_comb
    begin
        unique case (cnt_reg)
            3'd1:    begin opx = ua_reg[47:24]; opy = ub_reg[47:24]; end
            3'd2:    begin opx = ua_reg[47:24]; opy = ub_reg[23:0];  end
            3'd3:    begin opx = ua_reg[23:0];  opy = ub_reg[47:24]; end
            default: begin opx = ua_reg[23:0];  opy = ub_reg[23:0];  end
        endcase
        pp = 48'(opx) * 48'(opy);
        pr = 49'(pp) + 49'h80_0000;
        m = {4'b0, hh_reg, 24'b0} + 51'(acc_reg);
        if (hsat_reg || m > 51'h1_0000_0000_0000)
        begin
            m = 51'h1_0000_0000_0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                ua_reg  <= a[47] ? 48'(-a) : 48'(a);
                ub_reg  <= b[47] ? 48'(-b) : 48'(b);
                neg_reg <= a[47] ^ b[47];
                cnt_reg <= 3'd1;
            end
            else if (cnt_reg != 3'd0)
            begin
                unique case (cnt_reg)
                    3'd1:
                    begin
                        hsat_reg <= (pp[47:23] != '0);
                        hh_reg   <= pp[22:0];
                    end
                    3'd2: acc_reg <= 50'(pp);
                    3'd3: acc_reg <= acc_reg + 50'(pp);
                    3'd4: acc_reg <= acc_reg + 50'(pr[48:24]);
                    default:
                    begin
                        if (neg_reg)
                            product_reg <= (m >= 51'h8000_0000_0000) ? QMIN : -q_t'(m[47:0]);
                        else
                            product_reg <= (m >= 51'h8000_0000_0000) ? QMAX : q_t'(m[47:0]);
                        done_reg <= 1'b1;
                    end
                endcase
                cnt_reg <= (cnt_reg == 3'd5) ? 3'd0 : cnt_reg + 3'd1;
            end
        end
    end

    assign done    = done_reg;
    assign product = product_reg;
endmodule

FILE: src/akf_div.sv
// reciprocal 2^48/d rounded, one quotient bit per cycle
`timescale 1ns / 1ps
module akf_div import akf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  q_t   den,
    output logic done,
    output q_t   quotient
);
    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [CW-1:0] cnt_reg;
    logic [47:0]   d_reg, rem_reg;
    logic [49:0]   num_reg, q_reg;
    logic          done_reg;
    q_t            quotient_reg;
    logic [48:0]   trial;
    logic          ge;
    logic [49:0]   qn;

    always_comb
    begin
        trial = {rem_reg, num_reg[49]};
        ge    = trial >= {1'b0, d_reg};
        qn    = {q_reg[48:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                d_reg   <= den;
                rem_reg <= '0;
                q_reg   <= '0;
                num_reg <= {2'b01, 48'b0} + 50'(den[47:1]);
                cnt_reg <= CW'(DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= ge ? 48'(trial - 49'(d_reg)) : trial[47:0];
                q_reg   <= qn;
                num_reg <= {num_reg[48:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    quotient_reg <= (qn > 50'(QMAX)) ? QMAX : qn[47:0];
                    done_reg     <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;
endmodule

FILE: src/altitude_kalman_filter_3state.sv
// top level of the three-state altitude kalman filter
// The state and covariance live in one memory and every update is a micro-op that
// reads two operands, runs them through the single multiplier or the bit-serial
// reciprocal unit, or passes or halves one of them, then reads the addend and
// writes back. One item is worked on at a time and its estimate is offered when
// the last write is done, or at once when a non-positive innovation variance
// ends a correct item. After reset an initialization pass loads the covariance
// and state before the first item is taken; configuration writes are taken in
// any cycle.
`timescale 1ns / 1ps
`include "altitude_kalman_filter_3state_macros.svh"
module altitude_kalman_filter_3state import akf_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    akf_chan_if.sink     sample,
    akf_chan_if.source   estimate,
    akf_chan_if.sink     cfg
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RDYZ, S_OPS, S_MULW, S_DIVW, S_RDX, S_WB, S_OUT
    } state_t;

    state_t      state_reg;
    logic [4:0]  pc_reg;
    logic [3:0]  init_cnt_reg;
    logic        kind_reg, out_valid_reg;
    q_t          a_reg, z_reg, w_reg;
    logic [23:0] dt_reg;
    logic [31:0] alt_noise_reg, accel_noise_reg, bias_noise_reg;
    q_t          est_alt_reg, est_vel_reg, est_bias_reg;

    uop_t        op;
    addr_t       raddr_a, ram_waddr;
    q_t          rdata_a, rdata_b, ram_wdata, init_val;
    logic        ram_we;
    q_t          val_a, val_b, wb_val;
    addr_t       sel_a;
    logic        mul_start, mul_done, div_start, div_done;
    q_t          mul_q, div_q;
    logic        in_acc;

    function automatic q_t operand(addr_t ad, q_t ram_q, q_t a, logic [23:0] dt,
                                   logic [31:0] qa, logic [31:0] bn,
                                   logic [31:0] rn, q_t z);
        q_t v;
        if (ad < EXT_BASE)
        begin
            v = ram_q;
        end
        else
        begin
            unique case (ad)
                AD_A:    v = a;
                AD_DT:   v = q_t'({24'b0, dt});
                AD_QA:   v = q_t'({8'b0, qa, 8'b0});
                AD_BN:   v = q_t'({8'b0, bn, 8'b0});
                AD_RN:   v = q_t'({8'b0, rn, 8'b0});
                AD_Z:    v = z;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    assign op      = kind_reg ? correct_op(pc_reg) : predict_op(pc_reg);
    assign raddr_a = (state_reg == S_RDX) ? op.x : op.y;
    assign sel_a   = (state_reg == S_WB) ? op.x : op.y;
    assign in_acc  = sample.valid && sample.ready;

    always_comb
    begin
        val_a = operand(sel_a, rdata_a, a_reg, dt_reg, accel_noise_reg,
                        bias_noise_reg, alt_noise_reg, z_reg);
        val_b = operand(op.z, rdata_b, a_reg, dt_reg, accel_noise_reg,
                        bias_noise_reg, alt_noise_reg, z_reg);
        wb_val = op.sub ? sat49(49'(val_a) - 49'(w_reg))
                        : sat49(49'(val_a) + 49'(w_reg));
        unique case (init_cnt_reg)
            4'd0, 4'd4: init_val = ONE_Q;
            4'd8:       init_val = BIAS_P0;
            default:    init_val = '0;
        endcase
    end

    assign ram_we    = (state_reg == S_INIT) || (state_reg == S_WB);
    assign ram_waddr = (state_reg == S_INIT) ? addr_t'(init_cnt_reg) : op.dst;
    assign ram_wdata = (state_reg == S_INIT) ? init_val : wb_val;
    assign mul_start = (state_reg == S_OPS) && (op.mode == OP_MUL);
    assign div_start = (state_reg == S_OPS) && (op.mode == OP_DIV) && (val_a > 0);

    akf_ram #(.WIDTH(48), .DEPTH(32)) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (op.z),
        .rdata_b (rdata_b)
    );

    akf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (val_a),
        .b       (val_b),
        .done    (mul_done),
        .product (mul_q)
    );

    akf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .den      (val_a),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            pc_reg          <= '0;
            init_cnt_reg    <= '0;
            kind_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            alt_noise_reg   <= 32'd65536;
            accel_noise_reg <= 32'd32768;
            bias_noise_reg  <= 32'd0;
            est_alt_reg     <= '0;
            est_vel_reg     <= '0;
            est_bias_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    REG_ALT_NOISE:   alt_noise_reg   <= cfg.data.value;
                    REG_ACCEL_NOISE: accel_noise_reg <= cfg.data.value;
                    REG_BIAS_NOISE:  bias_noise_reg  <= cfg.data.value;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + 4'd1;
                    if (init_cnt_reg == 4'(STATE_WORDS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        kind_reg  <= sample.data.kind;
                        a_reg     <= q_t'({{8{sample.data.accel_sample[31]}},
                                           sample.data.accel_sample, 8'b0});
                        z_reg     <= q_t'({{8{sample.data.measured_altitude[31]}},
                                           sample.data.measured_altitude, 8'b0});
                        dt_reg    <= sample.data.time_step;
                        pc_reg    <= '0;
                        state_reg <= S_RDYZ;
                    end
                end
                S_RDYZ: state_reg <= S_OPS;
                S_OPS:
                begin
                    unique case (op.mode)
                        OP_MUL: state_reg <= S_MULW;
                        OP_PASS:
                        begin
                            w_reg     <= val_a;
                            state_reg <= S_RDX;
                        end
                        OP_HALF:
                        begin
                            w_reg     <= val_a >>> 1;
                            state_reg <= S_RDX;
                        end
                        OP_DIV:
                        begin
                            // non-positive innovation variance leaves state alone
                            if (val_a > 0)
                                state_reg <= S_DIVW;
                            else
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                        end
                        default: state_reg <= S_RDX;
                    endcase
                end
                S_MULW:
                begin
                    if (mul_done)
                    begin
                        w_reg     <= mul_q;
                        state_reg <= S_RDX;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        w_reg     <= div_q;
                        state_reg <= S_RDX;
                    end
                end
                S_RDX: state_reg <= S_WB;
                S_WB:
                begin
                    if (op.dst == AD_ALT) est_alt_reg <= wb_val;
                    if (op.dst == AD_VEL) est_vel_reg <= wb_val;
                    if (op.dst == AD_BIAS) est_bias_reg <= wb_val;
                    if (op.last)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 5'd1;
                        state_reg <= S_RDYZ;
                    end
                end
                S_OUT:
                begin
                    if (estimate.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign estimate.valid = out_valid_reg;
    assign estimate.data.altitude_estimate = to_port(est_alt_reg);
    assign estimate.data.velocity_estimate = to_port(est_vel_reg);
    assign estimate.data.bias_estimate     = to_port(est_bias_reg);

    `AKF_ASSERT(a_wr_range, !ram_we || ram_waddr < EXT_BASE, "write outside state memory")
    `AKF_ASSERT(a_mul_owner, !mul_done || state_reg == S_MULW, "stray product")
    `AKF_ASSERT(a_div_owner, !div_done || state_reg == S_DIVW, "stray quotient")
    `AKF_ASSERT_NEXT(a_accept, in_acc, state_reg == S_RDYZ && pc_reg == '0 && !out_valid_reg, "item start")
endmodule

FILE: dv/altitude_kalman_filter_3state_tb.sv
// testbench for the altitude kalman filter: directed and random predict/correct items vs a fixed-point predictor
`timescale 1ns / 1ps
module altitude_kalman_filter_3state_tb;
    import akf_pkg::*;

    localparam longint LIMIT = 3000000;

    logic clk;
    logic rst_n;

    akf_chan_if #(.payload_t(akf_in_t))  sample ();
    akf_chan_if #(.payload_t(akf_out_t)) estimate ();
    akf_chan_if #(.payload_t(akf_cfg_t)) cfg ();

    altitude_kalman_filter_3state dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample.sink),
        .estimate(estimate.source),
        .cfg(cfg.sink)
    );

    // predictor state
    logic [31:0] meas_var;
    logic [31:0] accel_var;
    logic [31:0] drift_var;
    q_t alt_q;
    q_t vel_q;
    q_t bias_q;
    q_t cov [9];

    akf_in_t  pending_items [$];
    akf_out_t expected_estimates [$];
    int mismatches;
    int accepted_count;
    int total_items;
    bit calm;
    longint cycle_count;
    int hold_cycles;
    int sink_hold;
    int src_gap;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic q_t clamp(logic signed [63:0] v);
        q_t r;
        if (v > 64'sh7FFF_FFFF_FFFF) r = QMAX;
        else if (v < -64'sh8000_0000_0000) r = QMIN;
        else r = v[47:0];
        return r;
    endfunction

    function automatic q_t add_q(q_t a, q_t b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return clamp(s);
    endfunction

    function automatic q_t sub_q(q_t a, q_t b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return clamp(s);
    endfunction

    function automatic q_t mul_q(q_t a, q_t b);
        logic [47:0] ua;
        logic [47:0] ub;
        logic [95:0] p;
        logic [95:0] m;
        logic signed [63:0] v;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 48'(-64'(a)) : a;
        ub = b < 0 ? 48'(-64'(b)) : b;
        p = 96'(ua) * 96'(ub);
        m = (p + 96'(1 << 23)) >> 24;
        if (m > 96'(64'd1 << 48)) m = 96'(64'd1 << 48);
        v = neg ? -64'(m) : 64'(m);
        return clamp(v);
    endfunction

    function automatic logic [31:0] port_of(q_t x);
        logic signed [63:0] y;
        logic signed [63:0] r;
        y = 64'(x) + 64'sd128;
        r = y >>> 8;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic filter_reset();
        meas_var = 32'd65536;
        accel_var = 32'd32768;
        drift_var = 32'd0;
        alt_q = '0;
        vel_q = '0;
        bias_q = '0;
        foreach (cov[i]) cov[i] = '0;
        cov[0] = ONE_Q;
        cov[4] = ONE_Q;
        cov[8] = BIAS_P0;
    endtask

    task automatic propagate(q_t a, q_t dt);
        q_t acc, dd, hf, d3, d4, qa;
        q_t t00, t01, t02, t10, t11, t12, t20, t21, t22;
        qa = q_t'({16'd0, accel_var, 8'd0});
        acc = sub_q(a, bias_q);
        vel_q = add_q(vel_q, mul_q(acc, dt));
        alt_q = add_q(alt_q, mul_q(vel_q, dt));
        dd = mul_q(dt, dt);
        hf = dd >>> 1;
        d3 = mul_q(hf, dt);
        d4 = mul_q(hf, hf);
        t00 = sub_q(add_q(cov[0], mul_q(dt, cov[3])), mul_q(hf, cov[6]));
        t01 = sub_q(add_q(cov[1], mul_q(dt, cov[4])), mul_q(hf, cov[7]));
        t02 = sub_q(add_q(cov[2], mul_q(dt, cov[5])), mul_q(hf, cov[8]));
        t10 = sub_q(cov[3], mul_q(dt, cov[6]));
        t11 = sub_q(cov[4], mul_q(dt, cov[7]));
        t12 = sub_q(cov[5], mul_q(dt, cov[8]));
        t20 = cov[6];
        t21 = cov[7];
        t22 = cov[8];
        cov[0] = sub_q(add_q(t00, mul_q(dt, t01)), mul_q(hf, t02));
        cov[1] = sub_q(t01, mul_q(dt, t02));
        cov[2] = t02;
        cov[3] = sub_q(add_q(t10, mul_q(dt, t11)), mul_q(hf, t12));
        cov[4] = sub_q(t11, mul_q(dt, t12));
        cov[5] = t12;
        cov[6] = sub_q(add_q(t20, mul_q(dt, t21)), mul_q(hf, t22));
        cov[7] = sub_q(t21, mul_q(dt, t22));
        cov[8] = t22;
        cov[0] = add_q(cov[0], mul_q(d4, qa));
        cov[1] = add_q(cov[1], mul_q(d3, qa));
        cov[3] = add_q(cov[3], mul_q(d3, qa));
        cov[4] = add_q(cov[4], mul_q(dd, qa));
        cov[8] = add_q(cov[8], q_t'({16'd0, drift_var, 8'd0}));
    endtask

    task automatic update_altitude(q_t z);
        q_t innov, den, s, kz, kv, ka, pzz, pzv, pza;
        logic [63:0] ud;
        logic [63:0] qt;
        innov = sub_q(z, alt_q);
        den = add_q(cov[0], q_t'({16'd0, meas_var, 8'd0}));
        if (den <= 0) return;
        ud = 64'(den);
        qt = ((64'd1 << 48) + ud / 2) / ud;
        if (qt > 64'(QMAX)) qt = 64'(QMAX);
        s = qt[47:0];
        kz = mul_q(cov[0], s);
        kv = mul_q(cov[3], s);
        ka = mul_q(cov[6], s);
        alt_q = add_q(alt_q, mul_q(kz, innov));
        vel_q = add_q(vel_q, mul_q(kv, innov));
        bias_q = add_q(bias_q, mul_q(ka, innov));
        pzz = cov[0];
        pzv = cov[1];
        pza = cov[2];
        cov[6] = sub_q(cov[6], mul_q(ka, pzz));
        cov[7] = sub_q(cov[7], mul_q(ka, pzv));
        cov[8] = sub_q(cov[8], mul_q(ka, pza));
        cov[3] = sub_q(cov[3], mul_q(kv, pzz));
        cov[4] = sub_q(cov[4], mul_q(kv, pzv));
        cov[5] = sub_q(cov[5], mul_q(kv, pza));
        cov[0] = sub_q(pzz, mul_q(kz, pzz));
        cov[1] = sub_q(pzv, mul_q(kz, pzv));
        cov[2] = sub_q(pza, mul_q(kz, pza));
    endtask

    task automatic predict_estimate(akf_in_t it);
        akf_out_t o;
        if (it.kind == 1'b0)
            propagate(q_t'({{8{it.accel_sample[31]}}, it.accel_sample, 8'd0}),
                      q_t'({24'd0, it.time_step}));
        else
            update_altitude(q_t'({{8{it.measured_altitude[31]}}, it.measured_altitude, 8'd0}));
        o.altitude_estimate = port_of(alt_q);
        o.velocity_estimate = port_of(vel_q);
        o.bias_estimate = port_of(bias_q);
        expected_estimates.push_back(o);
    endtask

    function automatic akf_in_t rand_item(bit wide);
        akf_in_t it;
        it.kind = ($urandom_range(0, 2) == 0);
        it.accel_sample = wide ? $urandom : 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        it.time_step = wide ? 24'($urandom) : 24'($urandom_range(1000, 400000));
        it.measured_altitude = wide ? $urandom
            : 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
        return it;
    endfunction

    function automatic akf_in_t mk_item(logic k, logic [31:0] a, logic [23:0] dt, logic [31:0] z);
        akf_in_t it;
        it.kind = k;
        it.accel_sample = a;
        it.time_step = dt;
        it.measured_altitude = z;
        return it;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= '{index: idx, value: val};
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_ALT_NOISE: meas_var = val;
            REG_ACCEL_NOISE: accel_var = val;
            default: drift_var = val;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_estimates.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_random(int n, bit wide_mix);
        repeat (n)
        begin
            pending_items.push_back(rand_item(wide_mix && $urandom_range(0, 9) == 0));
            total_items++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid <= 1'b0;
            sample.data <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                predict_estimate(sample.data);
                void'(pending_items.pop_front());
            end
            if (sample.valid && !sample.ready)
            begin
            end
            else if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                sample.valid <= 1'b0;
            end
            else
            begin
                if (pending_items.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 7) == 0)
                    begin
                        src_gap <= $urandom_range(0, 5);
                        sample.valid <= 1'b0;
                    end
                    else
                    begin
                        sample.valid <= 1'b1;
                        sample.data <= pending_items[0];
                    end
                end
                else
                    sample.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estimate.ready <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (estimate.valid && estimate.ready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected estimate %h", estimate.data);
                end
                else
                begin
                    automatic akf_out_t e = expected_estimates.pop_front();
                    if (e !== estimate.data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("estimate mismatch alt exp %h got %h vel exp %h got %h bias exp %h got %h",
                                     e.altitude_estimate, estimate.data.altitude_estimate,
                                     e.velocity_estimate, estimate.data.velocity_estimate,
                                     e.bias_estimate, estimate.data.bias_estimate);
                    end
                end
                accepted_count++;
            end
            if (hold_cycles > 0)
                estimate.ready <= 1'b0;
            else if (sink_hold > 0)
            begin
                sink_hold <= sink_hold - 1;
                estimate.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_hold <= $urandom_range(0, 5);
                estimate.ready <= 1'b0;
            end
            else
                estimate.ready <= 1'b1;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        mismatches = 0;
        accepted_count = 0;
        total_items = 0;
        calm = 0;
        hold_cycles = 0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        filter_reset();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // directed extremes at reset settings
        pending_items.push_back(mk_item(1'b0, 32'h0001_0000, 24'd0, 32'hFFFF_FFFF));
        pending_items.push_back(mk_item(1'b1, 32'h8000_0000, 24'hFFFFFF, 32'h0010_0000));
        pending_items.push_back(mk_item(1'b0, 32'h7FFF_FFFF, 24'hFFFFFF, 32'h7FFF_FFFF));
        pending_items.push_back(mk_item(1'b0, 32'h8000_0000, 24'h800000, 32'h8000_0000));
        pending_items.push_back(mk_item(1'b1, 32'hFFFF_FFFF, 24'd1, 32'h7FFF_FFFF));
        pending_items.push_back(mk_item(1'b1, 32'h0, 24'd0, 32'h8000_0000));
        pending_items.push_back(mk_item(1'b0, 32'h0, 24'd1, 32'h0));
        pending_items.push_back(mk_item(1'b1, 32'h0, 24'd0, 32'h0));
        total_items += 8;
        drain();

        // zero measurement noise, zero process noise: innovation variance can reach zero
        write_reg(REG_ALT_NOISE, 32'd0);
        write_reg(REG_ACCEL_NOISE, 32'd0);
        write_reg(REG_BIAS_NOISE, 32'd0);
        repeat (6) pending_items.push_back(mk_item(1'b1, 32'h0, 24'd0, 32'h0005_0000));
        pending_items.push_back(mk_item(1'b0, 32'h0002_0000, 24'h100000, 32'h0));
        pending_items.push_back(mk_item(1'b1, 32'h0, 24'd0, 32'h0005_0000));
        total_items += 8;
        drain();

        // maximal noise values
        write_reg(REG_ALT_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_ACCEL_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_BIAS_NOISE, 32'hFFFF_FFFF);
        queue_random(40, 1);
        // receiver holds off while the sender keeps offering
        hold_cycles = 3000;
        drain();

        // nominal filter settings
        write_reg(REG_ALT_NOISE, 32'h0000_8000);
        write_reg(REG_ACCEL_NOISE, 32'h0000_4000);
        write_reg(REG_BIAS_NOISE, 32'h0000_0010);
        queue_random(300, 1);
        drain();

        write_reg(REG_ALT_NOISE, $urandom);
        write_reg(REG_ACCEL_NOISE, $urandom);
        write_reg(REG_BIAS_NOISE, $urandom_range(0, 65536));
        queue_random(250, 1);
        drain();

        calm = 1;
        queue_random(100, 0);
        drain();

        if (mismatches == 0 && expected_estimates.size() == 0 && accepted_count == total_items)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
